// ----- rtl/running_lcm_of_cycle_lengths_assert.svh -----
// Assertion macros used by the checker of the running multiple block.
`ifndef RUNNING_LCM_OF_CYCLE_LENGTHS_ASSERT_SVH
`define RUNNING_LCM_OF_CYCLE_LENGTHS_ASSERT_SVH

// Check a property while out of reset.
`define RLCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RLCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rlcm_pkg.sv -----
`timescale 1ns / 1ps

package rlcm_pkg;

   localparam int unsigned ValW  = 31;
   localparam int unsigned TimeW = 16;
   localparam int unsigned LenW  = TimeW + 1;
   localparam int unsigned ProdW = ValW + TimeW;
   localparam int unsigned PcW   = 5;

   localparam logic [ValW-1:0] LimitReset = 31'd1000000;

   typedef struct packed {
      logic              kind;
      logic signed [15:0] open_time;
      logic signed [15:0] close_time;
   } req_type;

   typedef struct packed {
      logic [30:0] multiple;
      logic [2:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_BAD_LEN = 3'd1,
      STAT_OVER    = 3'd2,
      STAT_SAT     = 3'd3,
      STAT_IGNORED = 3'd4
   } stat_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_MOD_START,
      OP_EUCLID,
      OP_QUOT_START,
      OP_MUL,
      OP_FOLD,
      OP_RESTART,
      OP_IGNORE,
      OP_BAD_LEN,
      OP_ZERO,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_RESTART,
      C_STOPPED,
      C_LEN_BAD,
      C_A_ZERO,
      C_Y_ZERO,
      C_DIV_BUSY,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PcW-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic req_fire;
      logic restart;
      logic stopped;
      logic len_bad;
      logic a_zero;
      logic y_zero;
      logic div_busy;
      logic out_busy;
   } flags_type;

   localparam logic [PcW-1:0] PC_IDLE        = 5'd0;
   localparam logic [PcW-1:0] PC_RESTART_CHK = 5'd1;
   localparam logic [PcW-1:0] PC_STOP_CHK    = 5'd2;
   localparam logic [PcW-1:0] PC_LEN_CHK     = 5'd3;
   localparam logic [PcW-1:0] PC_ZERO_CHK    = 5'd4;
   localparam logic [PcW-1:0] PC_EUCLID      = 5'd5;
   localparam logic [PcW-1:0] PC_MOD_START   = 5'd6;
   localparam logic [PcW-1:0] PC_MOD_WAIT    = 5'd7;
   localparam logic [PcW-1:0] PC_MOD_SHIFT   = 5'd8;
   localparam logic [PcW-1:0] PC_QUOT_START  = 5'd9;
   localparam logic [PcW-1:0] PC_QUOT_WAIT   = 5'd10;
   localparam logic [PcW-1:0] PC_MUL         = 5'd11;
   localparam logic [PcW-1:0] PC_FOLD        = 5'd12;
   localparam logic [PcW-1:0] PC_RESTART     = 5'd13;
   localparam logic [PcW-1:0] PC_IGNORE      = 5'd14;
   localparam logic [PcW-1:0] PC_BAD_LEN     = 5'd15;
   localparam logic [PcW-1:0] PC_ZERO        = 5'd16;
   localparam logic [PcW-1:0] PC_EMIT        = 5'd17;
   localparam logic [PcW-1:0] PC_RETURN      = 5'd18;

   function automatic uword_type ucode(logic [PcW-1:0] pc);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
      unique case (pc)
         PC_IDLE:        w = '{op: OP_ACCEPT,     cond: C_NO_REQ,   target: PC_IDLE};
         PC_RESTART_CHK: w = '{op: OP_NOP,        cond: C_RESTART,  target: PC_RESTART};
         PC_STOP_CHK:    w = '{op: OP_NOP,        cond: C_STOPPED,  target: PC_IGNORE};
         PC_LEN_CHK:     w = '{op: OP_NOP,        cond: C_LEN_BAD,  target: PC_BAD_LEN};
         PC_ZERO_CHK:    w = '{op: OP_NOP,        cond: C_A_ZERO,   target: PC_ZERO};
         PC_EUCLID:      w = '{op: OP_NOP,        cond: C_Y_ZERO,   target: PC_QUOT_START};
         PC_MOD_START:   w = '{op: OP_MOD_START,  cond: C_NEVER,    target: PC_IDLE};
         PC_MOD_WAIT:    w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: PC_MOD_WAIT};
         PC_MOD_SHIFT:   w = '{op: OP_EUCLID,     cond: C_ALWAYS,   target: PC_EUCLID};
         PC_QUOT_START:  w = '{op: OP_QUOT_START, cond: C_NEVER,    target: PC_IDLE};
         PC_QUOT_WAIT:   w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: PC_QUOT_WAIT};
         PC_MUL:         w = '{op: OP_MUL,        cond: C_NEVER,    target: PC_IDLE};
         PC_FOLD:        w = '{op: OP_FOLD,       cond: C_ALWAYS,   target: PC_EMIT};
         PC_RESTART:     w = '{op: OP_RESTART,    cond: C_ALWAYS,   target: PC_EMIT};
         PC_IGNORE:      w = '{op: OP_IGNORE,     cond: C_ALWAYS,   target: PC_EMIT};
         PC_BAD_LEN:     w = '{op: OP_BAD_LEN,    cond: C_ALWAYS,   target: PC_EMIT};
         PC_ZERO:        w = '{op: OP_ZERO,       cond: C_NEVER,    target: PC_IDLE};
         PC_EMIT:        w = '{op: OP_EMIT,       cond: C_OUT_BUSY, target: PC_EMIT};
         PC_RETURN:      w = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
         default:        w = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/rlcm_div.sv -----
`timescale 1ns / 1ps

module rlcm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rlcm_pkg::ValW-1:0]     dividend,
   input  logic [rlcm_pkg::ValW-1:0]     divisor,
   output logic                          busy,
   output logic [rlcm_pkg::ValW-1:0]     quotient,
   output logic [rlcm_pkg::ValW-1:0]     remainder
);

   localparam int unsigned W    = rlcm_pkg::ValW;
   localparam int unsigned CntW = $clog2(W);
   localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    dsr_ff, dsr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;

   logic [W:0]      shifted;
   logic [W:0]      diff;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CntLast;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/rlcm_seq.sv -----
`timescale 1ns / 1ps

module rlcm_seq (
   input  logic                clock,
   input  logic                reset,
   input  rlcm_pkg::flags_type flags,
   output rlcm_pkg::uword_type uw
);

   logic [rlcm_pkg::PcW-1:0] pc_ff, pc_in;
   logic                     hit;

   assign uw = rlcm_pkg::ucode(pc_ff);

   always_comb begin
      unique case (uw.cond)
         rlcm_pkg::C_NEVER:    hit = 1'b0;
         rlcm_pkg::C_ALWAYS:   hit = 1'b1;
         rlcm_pkg::C_NO_REQ:   hit = ~flags.req_fire;
         rlcm_pkg::C_RESTART:  hit = flags.restart;
         rlcm_pkg::C_STOPPED:  hit = flags.stopped;
         rlcm_pkg::C_LEN_BAD:  hit = flags.len_bad;
         rlcm_pkg::C_A_ZERO:   hit = flags.a_zero;
         rlcm_pkg::C_Y_ZERO:   hit = flags.y_zero;
         rlcm_pkg::C_DIV_BUSY: hit = flags.div_busy;
         rlcm_pkg::C_OUT_BUSY: hit = flags.out_busy;
         default:              hit = 1'b1;
      endcase
      pc_in = hit ? uw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rlcm_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- rtl/running_lcm_of_cycle_lengths.sv -----
`timescale 1ns / 1ps
// Running least common multiple of cycle lengths.
// req_*: one item per transfer. kind 0 restarts the multiple at 1; kind 1 folds in
//   the cycle length open_time + close_time (signed, 17-bit exact sum).
// rsp_*: one result per item, the multiple after the item and a status code.
// csr_*: writes the limit register; always ready, write only while idle.
// One item is in work at a time, driven by a 19-step microprogram. A restart, an
// ignored item, an invalid length and a fold into a zero multiple go straight to
// the result; other folds run Euclid's algorithm, one division per remainder step,
// then a division for the quotient, a multiply and the fold. Divisions use the
// bit-serial divider (one quotient bit a cycle). A length fits 16 bits, so Euclid
// takes at most 23 remainder steps.
// The result sits in an output register: a new item is accepted while it waits,
// and that item's result is held back until the receiver takes the first.
// Reset (synchronous): multiple 1, not stopped, limit 1000000, no result pending.
module running_lcm_of_cycle_lengths (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rlcm_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rlcm_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rlcm_pkg::ValW-1:0]      csr_data
);

   localparam int unsigned ValW  = rlcm_pkg::ValW;
   localparam int unsigned TimeW = rlcm_pkg::TimeW;
   localparam int unsigned LenW  = rlcm_pkg::LenW;
   localparam int unsigned ProdW = rlcm_pkg::ProdW;

   rlcm_pkg::uword_type uw;
   rlcm_pkg::flags_type flags;

   logic [ValW-1:0]    limit_ff, limit_in;
   logic [ValW-1:0]    run_ff, run_in;
   logic               stopped_ff, stopped_in;
   rlcm_pkg::stat_type stat_ff, stat_in;
   logic               kind_ff, kind_in;
   logic [LenW-1:0]    len_ff, len_in;
   logic [ValW-1:0]    x_ff, x_in;
   logic [ValW-1:0]    y_ff, y_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   rlcm_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               out_busy;
   logic               div_start;
   logic [ValW-1:0]    div_dividend;
   logic [ValW-1:0]    div_divisor;
   logic               div_busy;
   logic [ValW-1:0]    div_quo;
   logic [ValW-1:0]    div_rem;

   assign req_ready = (uw.op == rlcm_pkg::OP_ACCEPT);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff & ~rsp_ready;

   always_comb begin
      flags.req_fire = req_fire;
      flags.restart  = ~kind_ff;
      flags.stopped  = stopped_ff;
      flags.len_bad  = len_ff[LenW-1] | (len_ff == '0);
      flags.a_zero   = (run_ff == '0);
      flags.y_zero   = (y_ff == '0);
      flags.div_busy = div_busy;
      flags.out_busy = out_busy;
   end

   rlcm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uw    (uw)
   );

   assign div_start    = (uw.op == rlcm_pkg::OP_MOD_START) ||
                         (uw.op == rlcm_pkg::OP_QUOT_START);
   assign div_dividend = (uw.op == rlcm_pkg::OP_QUOT_START) ? run_ff : x_ff;
   assign div_divisor  = (uw.op == rlcm_pkg::OP_QUOT_START) ? x_ff : y_ff;

   rlcm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      limit_in     = limit_ff;
      run_in       = run_ff;
      stopped_in   = stopped_ff;
      stat_in      = stat_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (csr_valid & csr_ready) begin
         limit_in = csr_data;
      end

      unique case (uw.op)
         rlcm_pkg::OP_ACCEPT: begin
            if (req_fire) begin
               kind_in = req_data.kind;
               len_in  = {req_data.open_time[TimeW-1], req_data.open_time} +
                         {req_data.close_time[TimeW-1], req_data.close_time};
               x_in    = run_ff;
               y_in    = {{(ValW-LenW){1'b0}}, len_in};
            end
         end
         rlcm_pkg::OP_EUCLID: begin
            x_in = y_ff;
            y_in = div_rem;
         end
         rlcm_pkg::OP_MUL: begin
            prod_in = ProdW'(div_quo) * ProdW'(len_ff[TimeW-1:0]);
         end
         rlcm_pkg::OP_FOLD: begin
            if (prod_ff[ProdW-1:ValW] != '0) begin
               run_in     = limit_ff;
               stopped_in = 1'b1;
               stat_in    = rlcm_pkg::STAT_SAT;
            end else if (prod_ff[ValW-1:0] > limit_ff) begin
               run_in     = prod_ff[ValW-1:0];
               stopped_in = 1'b1;
               stat_in    = rlcm_pkg::STAT_OVER;
            end else begin
               run_in  = prod_ff[ValW-1:0];
               stat_in = rlcm_pkg::STAT_OK;
            end
         end
         rlcm_pkg::OP_RESTART: begin
            run_in     = ValW'(1);
            stopped_in = 1'b0;
            stat_in    = rlcm_pkg::STAT_OK;
         end
         rlcm_pkg::OP_IGNORE:  stat_in = rlcm_pkg::STAT_IGNORED;
         rlcm_pkg::OP_BAD_LEN: stat_in = rlcm_pkg::STAT_BAD_LEN;
         rlcm_pkg::OP_ZERO:    stat_in = rlcm_pkg::STAT_OK;
         rlcm_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_in.multiple = run_ff;
               rsp_in.status   = stat_ff;
               rsp_valid_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= rlcm_pkg::LimitReset;
         run_ff       <= ValW'(1);
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         run_ff       <= run_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      kind_ff <= kind_in;
      len_ff  <= len_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/rlcm_chk.sv -----
`timescale 1ns / 1ps
`include "running_lcm_of_cycle_lengths_assert.svh"

module rlcm_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rlcm_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);

   logic [1:0] pend_ff, pend_in;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       csr_xfer;
   logic       rsp_stall;
   logic       over_fill;

   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid & rsp_ready;
   assign csr_xfer  = csr_valid & csr_ready;
   assign rsp_stall = rsp_valid & ~rsp_ready;
   assign over_fill = req_xfer & (pend_ff == 2'd2) & ~rsp_xfer;

   always_comb begin
      pend_in = pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `RLCM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_data), "stall broken")
   `RLCM_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result pending after reset")
   `RLCM_ASSERT(a_no_orphan, clock, reset, rsp_valid |-> pend_ff != 2'd0, "result without an item")
   `RLCM_ASSERT(a_depth, clock, reset, pend_ff != 2'd3 && !over_fill, "over two items outstanding")
   `RLCM_ASSERT(a_csr_idle, clock, reset, csr_xfer |-> pend_ff == 2'd0, "limit written mid-item")

endmodule

bind running_lcm_of_cycle_lengths rlcm_chk u_rlcm_chk (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned ValW       = rlcm_pkg::ValW;
   localparam int unsigned IdleLimit  = 20000;
   localparam int unsigned HoldCycles = 1500;
   localparam logic [ValW-1:0] LimitMax = 31'h7FFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rlcm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rlcm_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ValW-1:0]   csr_data = '0;

   running_lcm_of_cycle_lengths DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   logic [ValW-1:0] limit_q    = rlcm_pkg::LimitReset;
   logic [ValW-1:0] multiple_q = 31'd1;
   logic            stopped_q  = 1'b0;

   rlcm_pkg::rsp_type pending_results[$];
   int      status_tally[5];
   int      items_sent   = 0;
   int      results_seen = 0;
   int      limit_writes = 0;
   int      errors       = 0;
   int      gap_next     = 1;
   bit      tx_steady    = 1'b0;
   bit      rx_steady    = 1'b0;
   int      hold_asks    = 0;
   int      hold_done    = 0;
   int      idle_cycles  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic rlcm_pkg::req_type mk(bit kind, int o, int c);
      rlcm_pkg::req_type r;
      r.kind       = kind;
      r.open_time  = o[15:0];
      r.close_time = c[15:0];
      return r;
   endfunction

   // Running lcm of cycle lengths, advanced once per accepted item
   function automatic rlcm_pkg::rsp_type fold_cycle(rlcm_pkg::req_type r);
      int                 o, c, len;
      logic [31:0]        g, m, rem;
      logic [63:0]        prod;
      rlcm_pkg::stat_type st;
      rlcm_pkg::rsp_type  res;
      st = rlcm_pkg::STAT_OK;
      if (r.kind == 1'b0) begin
         multiple_q = 31'd1;
         stopped_q  = 1'b0;
      end else if (stopped_q) begin
         st = rlcm_pkg::STAT_IGNORED;
      end else begin
         o   = {{16{r.open_time[15]}}, r.open_time};
         c   = {{16{r.close_time[15]}}, r.close_time};
         len = o + c;
         if (len <= 0) begin
            st = rlcm_pkg::STAT_BAD_LEN;
         end else begin
            prod = '0;
            if (multiple_q != '0) begin
               g = {1'b0, multiple_q};
               m = len;
               while (m != 0) begin
                  rem = g % m;
                  g   = m;
                  m   = rem;
               end
               prod = 64'({1'b0, multiple_q} / g) * 64'(len);
            end
            if (prod > 64'(LimitMax)) begin
               multiple_q = limit_q;
               stopped_q  = 1'b1;
               st         = rlcm_pkg::STAT_SAT;
            end else if (prod > 64'(limit_q)) begin
               multiple_q = prod[ValW-1:0];
               stopped_q  = 1'b1;
               st         = rlcm_pkg::STAT_OVER;
            end else begin
               multiple_q = prod[ValW-1:0];
            end
         end
      end
      status_tally[int'(st)]++;
      res.multiple = multiple_q;
      res.status   = st;
      return res;
   endfunction

   function automatic rlcm_pkg::req_type make_item();
      int                r, len, o, lo, hi, t, v;
      rlcm_pkg::req_type it;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         it = mk(1'b0, $urandom, $urandom);
      end else if (r < 18) begin
         it = mk(1'b1, $urandom, $urandom);
      end else begin
         if ($urandom_range(0, 6) == 0) len = $urandom_range(1, 65534);
         else len = $urandom_range(1, 48);
         v = $urandom_range(0, 2);
         if (len > 32767 || v == 0) begin
            lo = (len > 32767) ? len - 32767 : 0;
            hi = (len > 32767) ? 32767 : len;
            o  = $urandom_range(lo, hi);
            it = mk(1'b1, o, len - o);
         end else begin
            t = $urandom_range(0, 32767 - len);
            if (v == 1) it = mk(1'b1, len + t, -t);
            else it = mk(1'b1, -t, len + t);
         end
      end
      return it;
   endfunction

   task automatic send_item(rlcm_pkg::req_type it);
      repeat (gap_next) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_results.insert(pending_results.size(), fold_cycle(it));
      items_sent++;
      gap_next = pick_gap(tx_steady);
      if (gap_next > 0) req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      if (gap_next == 0) begin
         req_valid <= 1'b0;
         gap_next = 1;
      end
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [ValW-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      limit_q = value;
      limit_writes++;
   endtask

   task automatic test_directed_cases();
      send_item(mk(1'b0, -32768, 32767));
      send_item(mk(1'b1, 3, 4));
      send_item(mk(1'b1, -32768, -32768));
      send_item(mk(1'b1, 0, 0));
      send_item(mk(1'b1, 32767, 32767));
      send_item(mk(1'b1, 32767, -32768));
      send_item(mk(1'b1, -1, 1));
      send_item(mk(1'b1, 1, 0));
      send_item(mk(1'b1, -5, 12));
      send_item(mk(1'b1, 32767, 32766));
      send_item(mk(1'b1, 10, 20));
      send_item(mk(1'b1, -40, 2));
      send_item(mk(1'b0, 32767, -32768));
      send_item(mk(1'b1, 1000, 0));
      send_item(mk(1'b1, 0, 999));
      send_item(mk(1'b1, 1001, 0));
      send_item(mk(1'b1, 7, 7));
      send_item(mk(1'b0, 0, 0));
      drain_results();
   endtask

   task automatic test_limit_edges();
      write_limit(LimitMax);
      send_item(mk(1'b0, 0, 0));
      send_item(mk(1'b1, 32767, 32767));
      send_item(mk(1'b1, 32767, 32766));
      send_item(mk(1'b0, 0, 0));
      send_item(mk(1'b1, 32767, 32767));
      write_limit('0);
      send_item(mk(1'b1, 32767, 32766));
      send_item(mk(1'b1, 2, 3));
      send_item(mk(1'b0, -1, -1));
      send_item(mk(1'b1, 2, 3));
      write_limit(31'd1);
      send_item(mk(1'b0, 5, 5));
      send_item(mk(1'b1, 1, 0));
      send_item(mk(1'b1, 0, 2));
      write_limit(31'd12);
      send_item(mk(1'b0, 0, 0));
      send_item(mk(1'b1, 4, 0));
      send_item(mk(1'b1, 0, 3));
      send_item(mk(1'b1, 5, 0));
      drain_results();
   endtask

   task automatic test_random_limits();
      logic [ValW-1:0] limits[6];
      limits[0] = rlcm_pkg::LimitReset;
      limits[1] = ValW'($urandom_range(2, 5000));
      limits[2] = LimitMax;
      limits[3] = 31'd1;
      limits[4] = ValW'($urandom_range(1, 32'h7FFF_FFFF));
      limits[5] = '0;
      foreach (limits[i]) begin
         write_limit(limits[i]);
         repeat (180) send_item(make_item());
      end
      write_limit(rlcm_pkg::LimitReset);
   endtask

   task automatic test_back_pressure();
      drain_results();
      tx_steady = 1'b1;
      hold_asks++;
      repeat (8) send_item(make_item());
      tx_steady = 1'b0;
      drain_results();
   endtask

   task automatic test_pause_and_resume();
      repeat (3) begin
         repeat (12) send_item(make_item());
         drain_results();
      end
   endtask

   task automatic test_no_idling();
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      repeat (60) send_item(make_item());
      drain_results();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold when asked
   initial begin
      int g;
      forever begin
         if (hold_asks != hold_done) begin
            hold_done++;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            g = pick_gap(rx_steady);
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rlcm_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: multiple %0d status %0d",
                   rsp_data.multiple, rsp_data.status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.multiple !== want.multiple) begin
               $error("multiple: expected %0d, got %0d", want.multiple, rsp_data.multiple);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("running_lcm_of_cycle_lengths regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_limit_edges();
      test_random_limits();
      test_back_pressure();
      test_pause_and_resume();
      test_no_idling();
      drain_results();
      repeat (50) @(posedge clock);
      $display("covered %0d items and %0d results over %0d limit writes",
               items_sent, results_seen, limit_writes);
      $display("status mix: ok %0d, bad length %0d, over %0d, saturated %0d, ignored %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("running_lcm_of_cycle_lengths regression: pass");
      end else begin
         $display("running_lcm_of_cycle_lengths regression: fail");
      end
      $finish;
   end

endmodule
